// ===== sv/acpiec_pkg.sv =====
// ----------------------------------------------------------------------------
// acpiec_pkg
// Shared types and constants of the ACPI embedded-controller port with
// host event query.
// ----------------------------------------------------------------------------
package acpiec_pkg;

	// Kinds of input transaction, carried on the slave-side tuser.
	typedef enum logic [1:0] {
		CMD_PORT_CMD   = 2'd0,
		CMD_PORT_DATA  = 2'd1,
		CMD_SET_EVENTS = 2'd2
	} cmd_kind_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_SMI_MASK      = 3'd0,
		REG_SCI_MASK      = 3'd1,
		REG_WAKE_MASK     = 3'd2,
		REG_READ_OPCODE   = 3'd3,
		REG_WRITE_OPCODE  = 3'd4,
		REG_QUERY_OPCODE  = 3'd5,
		REG_VERSION_VALUE = 3'd6
	} reg_index_t;

	// Field widths.
	localparam int unsigned CMD_W    = 2;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned WORD_W   = 32;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned IN_DATA_W  = 40;
	localparam int unsigned OUT_DATA_W = 80;

	// Reset values of the configuration registers.
	localparam logic [BYTE_W-1:0] READ_OPCODE_RST   = 8'h80;
	localparam logic [BYTE_W-1:0] WRITE_OPCODE_RST  = 8'h81;
	localparam logic [BYTE_W-1:0] QUERY_OPCODE_RST  = 8'h84;
	localparam logic [BYTE_W-1:0] VERSION_VALUE_RST = 8'h01;

	// Addresses of the readable bytes.
	localparam logic [BYTE_W-1:0] ADDR_VERSION  = 8'd0;
	localparam logic [BYTE_W-1:0] ADDR_TEST     = 8'd1;
	localparam logic [BYTE_W-1:0] ADDR_TEST_INV = 8'd2;

	// Saturation value of the data byte counter.
	localparam logic [1:0] DATA_COUNT_MAX = 2'd3;

	// One result item.
	typedef struct packed {
		logic [WORD_W-1:0] pending_events;
		logic [WORD_W-1:0] wake_events;
		logic              sci_flag;
		logic              smi_flag;
		logic              sci_pulse;
		logic              smi_pulse;
		logic [BYTE_W-1:0] reply_byte;
		logic              reply_valid;
	} result_t;

endpackage

// ===== sv/acpi_ec_port_with_event_query_core.sv =====
// ----------------------------------------------------------------------------
// acpi_ec_port_with_event_query_core
// ACPI embedded-controller command/data port with a host event register,
// query-and-clear of the lowest pending event and masked SMI/SCI flags.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake          Contents
// s_*       in         tvalid / tready    tuser: cmd; tdata: port_byte, event_word
// m_*       out        tvalid / tready    tdata: one result item
// cfg_*     in         valid / ready      cfg_index, cfg_data (register write)
//
// An accepted transaction is held in the input register; its result is
// computed from the state registers and loaded into the output register, and
// one transaction is taken every cycle while the master side keeps taking
// results. The state update of one transaction is visible to the next one in
// the following cycle.
// A stall on the master side holds the output register; the input register
// then still takes one transaction. Reset clears all state, the masks and the
// opcodes to their defaults. Configuration writes are always ready.
//
module acpi_ec_port_with_event_query_core #(
	parameter int unsigned EVENT_BITS = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// Slave side
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [acpiec_pkg::CMD_W-1:0]           s_tuser,  // [1:0] cmd
	// [7:0] port_byte, [39:8] event_word
	input  logic [acpiec_pkg::IN_DATA_W-1:0]       s_tdata,
	// Master side
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// [0] reply_valid, [8:1] reply_byte, [9] smi_pulse, [10] sci_pulse,
	// [11] smi_flag, [12] sci_flag, [44:13] wake_events,
	// [76:45] pending_events, [79:77] zero
	output logic [acpiec_pkg::OUT_DATA_W-1:0]      m_tdata,
	// Configuration write channel
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [acpiec_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [acpiec_pkg::WORD_W-1:0]          cfg_data
);
	import acpiec_pkg::*;

	// Configuration registers
	logic [WORD_W-1:0] smi_mask_q, sci_mask_q, wake_mask_q;
	logic [BYTE_W-1:0] read_opcode_q, write_opcode_q, query_opcode_q, version_value_q;

	// Block state
	logic [BYTE_W-1:0]     last_command_q, mem_address_q, test_byte_q;
	logic [1:0]            data_count_q;
	logic [EVENT_BITS-1:0] event_bits_q;
	logic                  smi_status_q, sci_status_q;

	// Input register
	logic              valid_s1;
	logic [CMD_W-1:0]  cmd_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic [WORD_W-1:0] word_s1;

	// Output register
	logic    out_valid_q;
	result_t result_q;

	// Next-state and result logic
	logic                  advance;
	logic                  is_port;
	logic [BYTE_W-1:0]     last_command_n, mem_address_n, test_byte_n;
	logic [1:0]            data_count_n;
	logic [EVENT_BITS-1:0] event_bits_n, event_word_ext, lowest_bit;
	logic [BYTE_W-1:0]     query_index;
	logic                  do_refresh, smi_new, sci_new;
	logic                  smi_status_n, sci_status_n;
	result_t               result_n;

	// Handshakes
	assign advance   = !out_valid_q || m_tready;
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = OUT_DATA_W'(result_q);

	// Lowest pending event and its 1-based number.
	assign lowest_bit = event_bits_q & (~event_bits_q + EVENT_BITS'(1));
	always_comb begin
		query_index = '0;
		for (int i = 0; i < EVENT_BITS; i++) begin
			if (lowest_bit[i]) begin
				query_index = query_index | BYTE_W'(i + 1);
			end
		end
	end

	assign event_word_ext = EVENT_BITS'(word_s1);
	assign is_port = (cmd_s1 == CMD_PORT_CMD) || (cmd_s1 == CMD_PORT_DATA);

	// Transaction processing
	always_comb begin
		last_command_n = last_command_q;
		mem_address_n  = mem_address_q;
		data_count_n   = data_count_q;
		test_byte_n    = test_byte_q;
		event_bits_n   = event_bits_q;
		do_refresh     = 1'b0;
		result_n       = '0;

		if (cmd_s1 == CMD_PORT_CMD) begin
			last_command_n = byte_s1;
			data_count_n   = 2'd0;
		end else if (cmd_s1 == CMD_PORT_DATA) begin
			if (data_count_q == 2'd0) begin
				mem_address_n = byte_s1;
			end
			if (data_count_q < DATA_COUNT_MAX) begin
				data_count_n = data_count_q + 2'd1;
			end
		end

		if (is_port) begin
			priority if (last_command_n == read_opcode_q && data_count_n == 2'd1) begin
				result_n.reply_valid = 1'b1;
				priority if (mem_address_n == ADDR_VERSION) begin
					result_n.reply_byte = version_value_q;
				end else if (mem_address_n == ADDR_TEST) begin
					result_n.reply_byte = test_byte_q;
				end else if (mem_address_n == ADDR_TEST_INV) begin
					result_n.reply_byte = 8'hFF - test_byte_q;
				end else begin
					result_n.reply_byte = '0;
				end
			end else if (last_command_n == write_opcode_q && data_count_n == 2'd2) begin
				if (mem_address_n == ADDR_TEST) begin
					test_byte_n = byte_s1;
				end
			end else if (last_command_n == query_opcode_q && data_count_n == 2'd0) begin
				result_n.reply_valid = 1'b1;
				result_n.reply_byte  = query_index;
				if (event_bits_q != '0) begin
					event_bits_n = event_bits_q & ~lowest_bit;
					do_refresh   = 1'b1;
				end
			end else begin
				result_n.reply_valid = 1'b0;
			end
		end else if (cmd_s1 == CMD_SET_EVENTS) begin
			if (event_word_ext != event_bits_q) begin
				event_bits_n = event_word_ext;
				do_refresh   = 1'b1;
			end
		end

		// Status flags follow any change of the event register.
		smi_new      = |(event_bits_n & EVENT_BITS'(smi_mask_q));
		sci_new      = |(event_bits_n & EVENT_BITS'(sci_mask_q));
		smi_status_n = do_refresh ? smi_new : smi_status_q;
		sci_status_n = do_refresh ? sci_new : sci_status_q;

		result_n.smi_pulse      = do_refresh && smi_new && !smi_status_q;
		result_n.sci_pulse      = is_port || (do_refresh && sci_new);
		result_n.smi_flag       = smi_status_n;
		result_n.sci_flag       = sci_status_n;
		result_n.pending_events = WORD_W'(event_bits_n);
		result_n.wake_events    = WORD_W'(event_bits_n) & wake_mask_q;
	end

	// Input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1  <= s_tuser;
			byte_s1 <= s_tdata[BYTE_W-1:0];
			word_s1 <= s_tdata[BYTE_W +: WORD_W];
		end
	end

	// Output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_q <= result_n;
		end
	end

	// Configuration registers and block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smi_mask_q      <= '0;
			sci_mask_q      <= '0;
			wake_mask_q     <= '0;
			read_opcode_q   <= READ_OPCODE_RST;
			write_opcode_q  <= WRITE_OPCODE_RST;
			query_opcode_q  <= QUERY_OPCODE_RST;
			version_value_q <= VERSION_VALUE_RST;
			last_command_q  <= '0;
			mem_address_q   <= '0;
			data_count_q    <= '0;
			test_byte_q     <= '0;
			event_bits_q    <= '0;
			smi_status_q    <= 1'b0;
			sci_status_q    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			// The user must send writes only while no transaction is in flight; the block itself does not enforce this.
			unique case (cfg_index)
				REG_SMI_MASK: begin
					smi_mask_q   <= cfg_data;
					smi_status_q <= |(event_bits_q & EVENT_BITS'(cfg_data));
				end
				REG_SCI_MASK: begin
					sci_mask_q   <= cfg_data;
					sci_status_q <= |(event_bits_q & EVENT_BITS'(cfg_data));
				end
				REG_WAKE_MASK:     wake_mask_q     <= cfg_data;
				REG_READ_OPCODE:   read_opcode_q   <= cfg_data[BYTE_W-1:0];
				REG_WRITE_OPCODE:  write_opcode_q  <= cfg_data[BYTE_W-1:0];
				REG_QUERY_OPCODE:  query_opcode_q  <= cfg_data[BYTE_W-1:0];
				REG_VERSION_VALUE: version_value_q <= cfg_data[BYTE_W-1:0];
				default: begin
				end
			endcase
		end else if (advance && valid_s1) begin
			last_command_q <= last_command_n;
			mem_address_q  <= mem_address_n;
			data_count_q   <= data_count_n;
			test_byte_q    <= test_byte_n;
			event_bits_q   <= event_bits_n;
			smi_status_q   <= smi_status_n;
			sci_status_q   <= sci_status_n;
		end
	end

endmodule

// ===== sv/acpiec_checker.sv =====
// ----------------------------------------------------------------------------
// acpiec_checker
// Port-level checks of the ACPI embedded-controller port, bound to the top.
// ----------------------------------------------------------------------------
module acpiec_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  m_tvalid,
	input logic                                  m_tready,
	input logic [acpiec_pkg::OUT_DATA_W-1:0]     m_tdata
);
	import acpiec_pkg::*;

	result_t res;
	assign res = result_t'(m_tdata[$bits(result_t)-1:0]);

	// A result with no reply carries a zero reply byte.
	a_reply_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !res.reply_valid |-> res.reply_byte == '0)
		else $error("reply byte set without a reply");

	// A reply only comes from a port write, which always pulses SCI.
	a_reply_sci: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.reply_valid |-> res.sci_pulse)
		else $error("reply without an SCI pulse");

	// An SMI pulse is only sent together with a raised SMI flag.
	a_smi_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.smi_pulse |-> res.smi_flag)
		else $error("SMI pulse with the SMI flag low");

	// Wake events are a subset of the pending events.
	a_wake_subset: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res.wake_events & ~res.pending_events) == '0)
		else $error("wake event not pending");

	// A stalled result stays in place.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind acpi_ec_port_with_event_query_core acpiec_checker u_acpiec_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
